### rtl/nbps_pkg.sv
// shared types, codes and constants of the naive bayes posterior scorer
`default_nettype none

package nbps_pkg;

   localparam int NUM_CLASSES_DEF   = 39;
   localparam int NUM_HOURS_DEF     = 24;
   localparam int NUM_DAYS_DEF      = 7;
   localparam int NUM_DISTRICTS_DEF = 10;
   localparam int PROB_BITS_DEF     = 16;

   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam int CLASS_FIELD_W = 6;
   localparam int POST_FIELD_W  = 16;
   localparam int VALUE_FIELD_W = 16;

   localparam logic [CLASS_FIELD_W-1:0] CLASSES_RESET = 6'd39;

   localparam logic [CSR_ADDR_W-1:0] REG_CLASSES = 2'd0;

   localparam logic FUNC_WRITE    = 1'b0;
   localparam logic FUNC_CLASSIFY = 1'b1;

   localparam logic [1:0] TBL_HOUR  = 2'd0;
   localparam logic [1:0] TBL_DAY   = 2'd1;
   localparam logic [1:0] TBL_DIST  = 2'd2;
   localparam logic [1:0] TBL_PRIOR = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_ZERO  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DRD,
      ST_DLD,
      ST_DIV,
      ST_PUSH
   } state_type;

   typedef enum logic [2:0] {
      PH_PRIOR,
      PH_HOUR,
      PH_DAY,
      PH_DIST,
      PH_LAST_MUL,
      PH_ACC
   } phase_type;

endpackage

`default_nettype wire

### rtl/naive_bayes_posterior_scorer.sv
// naive bayes posterior scorer: table store, evidence pass and posterior division
// operation: a write item is stored as it is taken; a classify item runs an evidence pass
//   per class (four reads of the table memory and three multiplies), then a bit-serial
//   division per class
// throughput: one item at a time; after a write the next is taken at once, after a classify
//   once the last result of the item is in the output register
// reset: control state and classes_in_use (39) clear, tables are undefined until written
`default_nettype none

module naive_bayes_posterior_scorer #(
   parameter int NUM_CLASSES   = nbps_pkg::NUM_CLASSES_DEF,
   parameter int NUM_HOURS     = nbps_pkg::NUM_HOURS_DEF,
   parameter int NUM_DAYS      = nbps_pkg::NUM_DAYS_DEF,
   parameter int NUM_DISTRICTS = nbps_pkg::NUM_DISTRICTS_DEF,
   parameter int PROB_BITS     = nbps_pkg::PROB_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // entry_row, entry_class, entry_value, hour, weekday, district
   input  wire logic [nbps_pkg::REQ_DATA_W-1:0] req_tdata,
   // func, table_sel
   input  wire logic [nbps_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // class_index, posterior
   output logic [nbps_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast,
   // status
   output logic [nbps_pkg::RSP_USER_W-1:0]      rsp_tuser,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [nbps_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [nbps_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [nbps_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import nbps_pkg::*;

   localparam int CLS_W      = $clog2(NUM_CLASSES);
   localparam int TOTAL_ROWS = NUM_HOURS + NUM_DAYS + NUM_DISTRICTS + 1;
   localparam int ROW_W      = $clog2(TOTAL_ROWS);
   localparam int TAB_DEPTH  = TOTAL_ROWS << CLS_W;
   localparam int TAB_AW     = ROW_W + CLS_W;
   localparam int EVID_DEPTH = 1 << CLS_W;
   localparam int MUL_A_W    = 3 * PROB_BITS;
   localparam int ACC_W      = 4 * PROB_BITS;
   localparam int SUM_W      = ACC_W + CLS_W;
   localparam int STEP_W     = $clog2(PROB_BITS);
   localparam int BASE_DAY   = NUM_HOURS;
   localparam int BASE_DIST  = NUM_HOURS + NUM_DAYS;
   localparam int BASE_PRIOR = NUM_HOURS + NUM_DAYS + NUM_DISTRICTS;

   // request fields
   logic                      f_func;
   logic [1:0]                f_sel;
   logic [4:0]                f_row;
   logic [5:0]                f_class;
   logic [VALUE_FIELD_W-1:0]  f_value;
   logic [4:0]                f_hour;
   logic [2:0]                f_day;
   logic [3:0]                f_dist;

   assign f_func  = req_tuser[0];
   assign f_sel   = req_tuser[2:1];
   assign f_row   = req_tdata[4:0];
   assign f_class = req_tdata[10:5];
   assign f_value = req_tdata[26:11];
   assign f_hour  = req_tdata[31:27];
   assign f_day   = req_tdata[34:32];
   assign f_dist  = req_tdata[38:35];

   // control and datapath registers
   state_type                 state_ff, state_in;
   phase_type                 phase_ff, phase_in;
   logic [CLASS_FIELD_W-1:0]  classes_ff, classes_in;
   logic [CLS_W-1:0]          cls_ff, cls_in;
   logic [CLS_W-1:0]          last_ff, last_in;
   logic [4:0]                hour_ff, hour_in;
   logic [2:0]                day_ff, day_in;
   logic [3:0]                dist_ff, dist_in;
   logic [1:0]                status_ff, status_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [SUM_W-1:0]          rem_ff, rem_in;
   logic                      int_ff, int_in;
   logic [PROB_BITS-1:0]      quo_ff, quo_in;
   logic [PROB_BITS-1:0]      post_ff, post_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CLASS_FIELD_W-1:0]  rsp_class_ff, rsp_class_in;
   logic [POST_FIELD_W-1:0]   rsp_post_ff, rsp_post_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;

   // memories
   logic [PROB_BITS-1:0]      tab_mem [TAB_DEPTH];
   logic [PROB_BITS-1:0]      tab_q_ff;
   logic                      tab_we;
   logic [TAB_AW-1:0]         tab_waddr;
   logic [TAB_AW-1:0]         tab_raddr;
   logic [PROB_BITS-1:0]      tab_wdata;
   logic [ACC_W-1:0]          evid_mem [EVID_DEPTH];
   logic [ACC_W-1:0]          evid_q_ff;
   logic                      evid_we;

   // helpers
   logic                      req_take;
   logic                      out_free;
   logic [ACC_W-1:0]          mul;
   logic [SUM_W-1:0]          sum_add;
   logic [SUM_W:0]            rem_dbl;
   logic                      rem_ge;
   logic [SUM_W-1:0]          evid_ext;
   logic [PROB_BITS-1:0]      quo_next;
   logic                      row_ok;
   logic [ROW_W-1:0]          wrow;
   logic                      obs_ok;
   logic [6:0]                n_eff;

   assign mul      = acc_ff[MUL_A_W-1:0] * tab_q_ff;
   assign sum_add  = sum_ff + SUM_W'(acc_ff);
   assign rem_dbl  = {rem_ff, 1'b0};
   assign rem_ge   = rem_dbl >= {1'b0, sum_ff};
   assign evid_ext = SUM_W'(evid_q_ff);
   assign quo_next = {quo_ff[PROB_BITS-2:0], rem_ge};
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      n_eff = {1'b0, classes_ff};
      if (classes_ff == '0) begin
         n_eff = 7'd1;
      end else if (int'(classes_ff) > NUM_CLASSES) begin
         n_eff = 7'(NUM_CLASSES);
      end
   end

   assign obs_ok = (int'(f_hour) < NUM_HOURS) && (int'(f_day) < NUM_DAYS) &&
                   (int'(f_dist) < NUM_DISTRICTS);

   always_comb begin
      row_ok = 1'b0;
      wrow   = ROW_W'(BASE_PRIOR);
      case (f_sel)
         TBL_HOUR: begin
            row_ok = int'(f_row) < NUM_HOURS;
            wrow   = ROW_W'(f_row);
         end
         TBL_DAY: begin
            row_ok = int'(f_row) < NUM_DAYS;
            wrow   = ROW_W'(BASE_DAY) + ROW_W'(f_row);
         end
         TBL_DIST: begin
            row_ok = int'(f_row) < NUM_DISTRICTS;
            wrow   = ROW_W'(BASE_DIST) + ROW_W'(f_row);
         end
         TBL_PRIOR: begin
            row_ok = 1'b1;
            wrow   = ROW_W'(BASE_PRIOR);
         end
         default: begin
            row_ok = 1'b0;
         end
      endcase
   end

   assign tab_we    = req_take && (f_func == FUNC_WRITE) && row_ok &&
                      (int'(f_class) < NUM_CLASSES);
   assign tab_waddr = {wrow, CLS_W'(f_class)};
   assign tab_wdata = PROB_BITS'(f_value);

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      classes_in    = classes_ff;
      cls_in        = cls_ff;
      last_in       = last_ff;
      hour_in       = hour_ff;
      day_in        = day_ff;
      dist_in       = dist_ff;
      status_in     = status_ff;
      acc_in        = acc_ff;
      sum_in        = sum_ff;
      rem_in        = rem_ff;
      int_in        = int_ff;
      quo_in        = quo_ff;
      post_in       = post_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_class_in  = rsp_class_ff;
      rsp_post_in   = rsp_post_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      tab_raddr     = {ROW_W'(BASE_PRIOR), cls_ff};
      evid_we       = 1'b0;

      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          csr_paddr == REG_CLASSES) begin
         classes_in = csr_pwdata[CLASS_FIELD_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take && f_func == FUNC_CLASSIFY) begin
               cls_in  = '0;
               last_in = CLS_W'(n_eff - 7'd1);
               hour_in = f_hour;
               day_in  = f_day;
               dist_in = f_dist;
               sum_in  = '0;
               post_in = '0;
               if (obs_ok) begin
                  status_in = STAT_OK;
                  phase_in  = PH_PRIOR;
                  state_in  = ST_SUM;
               end else begin
                  status_in = STAT_RANGE;
                  state_in  = ST_PUSH;
               end
            end
         end
         ST_SUM: begin
            case (phase_ff)
               PH_PRIOR: begin
                  tab_raddr = {ROW_W'(BASE_PRIOR), cls_ff};
                  phase_in  = PH_HOUR;
               end
               PH_HOUR: begin
                  acc_in    = ACC_W'(tab_q_ff);
                  tab_raddr = {ROW_W'(hour_ff), cls_ff};
                  phase_in  = PH_DAY;
               end
               PH_DAY: begin
                  acc_in    = mul;
                  tab_raddr = {ROW_W'(BASE_DAY) + ROW_W'(day_ff), cls_ff};
                  phase_in  = PH_DIST;
               end
               PH_DIST: begin
                  acc_in    = mul;
                  tab_raddr = {ROW_W'(BASE_DIST) + ROW_W'(dist_ff), cls_ff};
                  phase_in  = PH_LAST_MUL;
               end
               PH_LAST_MUL: begin
                  acc_in   = mul;
                  phase_in = PH_ACC;
               end
               PH_ACC: begin
                  sum_in   = sum_add;
                  evid_we  = 1'b1;
                  phase_in = PH_PRIOR;
                  if (cls_ff == last_ff) begin
                     cls_in = '0;
                     if (sum_add == '0) begin
                        status_in = STAT_ZERO;
                        post_in   = '0;
                        state_in  = ST_PUSH;
                     end else begin
                        state_in = ST_DRD;
                     end
                  end else begin
                     cls_in = cls_ff + 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_PRIOR;
               end
            endcase
         end
         ST_DRD: begin
            state_in = ST_DLD;
         end
         ST_DLD: begin
            int_in   = evid_ext >= sum_ff;
            rem_in   = (evid_ext >= sum_ff) ? evid_ext - sum_ff : evid_ext;
            quo_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = rem_ge ? SUM_W'(rem_dbl - {1'b0, sum_ff}) : SUM_W'(rem_dbl);
            quo_in  = quo_next;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(PROB_BITS - 1)) begin
               post_in  = int_ff ? '1 : quo_next;
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_class_in  = CLASS_FIELD_W'(cls_ff);
               rsp_post_in   = POST_FIELD_W'(post_ff);
               rsp_last_in   = (cls_ff == last_ff);
               rsp_status_in = status_ff;
               if (cls_ff == last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  cls_in = cls_ff + 1'b1;
                  if (status_ff == STAT_OK) begin
                     state_in = ST_DRD;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_PRIOR;
         classes_ff   <= CLASSES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         classes_ff   <= classes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cls_ff        <= cls_in;
      last_ff       <= last_in;
      hour_ff       <= hour_in;
      day_ff        <= day_in;
      dist_ff       <= dist_in;
      status_ff     <= status_in;
      acc_ff        <= acc_in;
      sum_ff        <= sum_in;
      rem_ff        <= rem_in;
      int_ff        <= int_in;
      quo_ff        <= quo_in;
      post_ff       <= post_in;
      step_ff       <= step_in;
      rsp_class_ff  <= rsp_class_in;
      rsp_post_ff   <= rsp_post_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   // probability tables, rows of hour, weekday, district, then priors
   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab_mem[tab_waddr] <= tab_wdata;
      end
      tab_q_ff <= tab_mem[tab_raddr];
   end

   // per class evidence products
   always_ff @(posedge clock) begin
      if (evid_we) begin
         evid_mem[cls_ff] <= acc_ff;
      end
      evid_q_ff <= evid_mem[cls_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - CLASS_FIELD_W - POST_FIELD_W)'(0), rsp_post_ff,
                        rsp_class_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_CLASSES) ? CSR_DATA_W'(classes_ff) : '0;

endmodule

`default_nettype wire

### rtl/nbps_checker.sv
// port level checks of the naive bayes posterior scorer and their binding
`default_nettype none

module nbps_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [nbps_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                            rsp_tlast,
   input wire logic [nbps_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import nbps_pkg::*;

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // failed classification gives zero posterior
   a_zero_post: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STAT_OK |-> rsp_tdata[21:6] == '0)
      else $error("nonzero posterior with error status");

   // no new item while a run is unfinished
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("item taken inside a run");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == STAT_OK || rsp_tuser == STAT_ZERO || rsp_tuser == STAT_RANGE)
      else $error("unknown status code");

endmodule

bind naive_bayes_posterior_scorer nbps_checker u_nbps_checker (.*);

`default_nettype wire

### tb/tb_naive_bayes_posterior_scorer.sv
// self-checking testbench for the naive bayes posterior scorer, with its own scoring predictor
`timescale 1ns / 1ps

module tb_naive_bayes_posterior_scorer;
   import nbps_pkg::*;

   typedef struct {
      logic        func;
      logic [1:0]  sel;
      logic [4:0]  row;
      logic [5:0]  cls;
      logic [15:0] val;
      logic [4:0]  hr;
      logic [2:0]  wd;
      logic [3:0]  ds;
   } scorer_req_type;

   typedef struct {
      logic [5:0]  cls;
      logic [15:0] post;
      logic        last;
      logic [1:0]  status;
   } posterior_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   naive_bayes_posterior_scorer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // scoring predictor state
   logic [15:0] hour_p  [NUM_HOURS_DEF][NUM_CLASSES_DEF];
   logic [15:0] day_p   [NUM_DAYS_DEF][NUM_CLASSES_DEF];
   logic [15:0] dist_p  [NUM_DISTRICTS_DEF][NUM_CLASSES_DEF];
   logic [15:0] prior_p [NUM_CLASSES_DEF];
   logic [5:0]  model_classes = CLASSES_RESET;

   // entries already written, as seen by the item generator
   bit hour_seen  [NUM_HOURS_DEF][NUM_CLASSES_DEF];
   bit day_seen   [NUM_DAYS_DEF][NUM_CLASSES_DEF];
   bit dist_seen  [NUM_DISTRICTS_DEF][NUM_CLASSES_DEF];
   bit prior_seen [NUM_CLASSES_DEF];
   int gen_classes = NUM_CLASSES_DEF;

   scorer_req_type item_backlog[$];
   posterior_type  posterior_q[$];
   scorer_req_type req_cur;
   int          req_gap = 0;
   int          rsp_stall = 0;
   logic        no_idle = 1'b0;
   logic        hold_off = 1'b0;
   bit          hold_request = 0;

   int items_queued = 0;
   int items_accepted = 0;
   int stim_count = 0;
   int posteriors_seen = 0;
   int mismatches = 0;
   int writes_kept = 0;
   int writes_dropped = 0;
   int scored_ok = 0;
   int scored_zero = 0;
   int scored_range = 0;
   int csr_writes = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d items accepted of %0d", items_accepted, items_queued);
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   function automatic int effective_classes(input logic [5:0] v);
      if (v == 0)
         return 1;
      if (v > NUM_CLASSES_DEF)
         return NUM_CLASSES_DEF;
      return int'(v);
   endfunction

   task automatic predict_posteriors(input scorer_req_type it);
      int          n;
      int          k;
      logic [1:0]  status;
      bit [127:0]  ev [NUM_CLASSES_DEF];
      bit [127:0]  total;
      bit [127:0]  quo;
      posterior_type  want;
      if (it.func == FUNC_WRITE) begin
         if (it.cls >= NUM_CLASSES_DEF || (it.sel == TBL_HOUR && it.row >= NUM_HOURS_DEF) ||
             (it.sel == TBL_DAY && it.row >= NUM_DAYS_DEF) ||
             (it.sel == TBL_DIST && it.row >= NUM_DISTRICTS_DEF)) begin
            writes_dropped++;
            return;
         end
         case (it.sel)
            TBL_HOUR: hour_p[it.row][it.cls] = it.val;
            TBL_DAY:  day_p[it.row[2:0]][it.cls] = it.val;
            TBL_DIST: dist_p[it.row[3:0]][it.cls] = it.val;
            default:  prior_p[it.cls] = it.val;
         endcase
         writes_kept++;
         return;
      end
      n = effective_classes(model_classes);
      status = STAT_OK;
      total = '0;
      if (it.hr >= NUM_HOURS_DEF || it.wd >= NUM_DAYS_DEF || it.ds >= NUM_DISTRICTS_DEF) begin
         status = STAT_RANGE;
      end else begin
         for (k = 0; k < n; k++) begin
            ev[k] = 128'(prior_p[k]);
            ev[k] = ev[k] * hour_p[it.hr][k];
            ev[k] = ev[k] * day_p[it.wd][k];
            ev[k] = ev[k] * dist_p[it.ds][k];
            total = total + ev[k];
         end
         if (total == 0)
            status = STAT_ZERO;
      end
      case (status)
         STAT_OK:   scored_ok++;
         STAT_ZERO: scored_zero++;
         default:   scored_range++;
      endcase
      for (k = 0; k < n; k++) begin
         want.cls = 6'(k);
         want.post = '0;
         if (status == STAT_OK) begin
            quo = (ev[k] << PROB_BITS_DEF) / total;
            want.post = (quo > 128'hFFFF) ? 16'hFFFF : quo[15:0];
         end
         want.last = (k == n - 1);
         want.status = status;
         posterior_q.push_back(want);
      end
   endtask

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 3);
   endfunction

   always @(posedge clock) begin : drive_req
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_posteriors(req_cur);
            items_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap = req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (item_backlog.size() > 0) begin
               req_cur = item_backlog.pop_front();
               req_tdata <= {1'b0, req_cur.ds, req_cur.wd, req_cur.hr, req_cur.val,
                             req_cur.cls, req_cur.row};
               req_tuser <= {req_cur.sel, req_cur.func};
               req_tvalid <= 1'b1;
               req_gap = draw_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_posterior();
      posterior_type want;
      if (posterior_q.size() == 0) begin
         flag_mismatch($sformatf("result for class %0d with nothing pending", rsp_tdata[5:0]));
         return;
      end
      want = posterior_q.pop_front();
      if (rsp_tdata[5:0] != want.cls)
         flag_mismatch($sformatf("class_index %0d, want %0d", rsp_tdata[5:0], want.cls));
      if (rsp_tdata[21:6] != want.post)
         flag_mismatch($sformatf("class %0d posterior %0d, want %0d",
                                 want.cls, rsp_tdata[21:6], want.post));
      if (rsp_tlast != want.last)
         flag_mismatch($sformatf("class %0d last %0b, want %0b", want.cls, rsp_tlast, want.last));
      if (rsp_tuser != want.status)
         flag_mismatch($sformatf("class %0d status %0d, want %0d",
                                 want.cls, rsp_tuser, want.status));
      posteriors_seen++;
   endtask

   always @(posedge clock) begin : watch_rsp
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_posterior();
            rsp_stall = draw_gap();
         end else if (rsp_stall > 0) begin
            rsp_stall = rsp_stall - 1;
         end
         rsp_tready <= (rsp_stall == 0) && !hold_off;
      end
   end

   // long receiver hold-off so the scorer backs up and stalls its input
   initial begin : receiver_hold
      wait (hold_request);
      repeat (30) @(posedge clock);
      hold_off <= 1'b1;
      repeat (600) @(posedge clock);
      hold_off <= 1'b0;
   end

   function automatic logic [15:0] draw_prob();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(1, 15));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic scorer_req_type random_item();
      scorer_req_type it;
      it.func = 1'($urandom);
      it.sel = 2'($urandom);
      it.row = 5'($urandom);
      it.cls = 6'($urandom);
      it.val = 16'($urandom);
      it.hr = 5'($urandom);
      it.wd = 3'($urandom);
      it.ds = 4'($urandom);
      return it;
   endfunction

   function automatic int row_limit(input logic [1:0] sel);
      case (sel)
         TBL_HOUR: return NUM_HOURS_DEF;
         TBL_DAY:  return NUM_DAYS_DEF;
         TBL_DIST: return NUM_DISTRICTS_DEF;
         default:  return 32;
      endcase
   endfunction

   task automatic queue_write(input logic [1:0] sel, input int row, input int cls,
                              input logic [15:0] val);
      scorer_req_type it;
      bit          kept;
      it = random_item();
      it.func = FUNC_WRITE;
      it.sel = sel;
      it.row = 5'(row);
      it.cls = 6'(cls);
      it.val = val;
      kept = 0;
      if (cls < NUM_CLASSES_DEF && row < row_limit(sel)) begin
         kept = 1;
         case (sel)
            TBL_HOUR: hour_seen[row][cls] = 1;
            TBL_DAY:  day_seen[row][cls] = 1;
            TBL_DIST: dist_seen[row][cls] = 1;
            default:  prior_seen[cls] = 1;
         endcase
      end
      item_backlog.push_back(it);
      items_queued++;
      if (kept)
         stim_count++;
   endtask

   // loads any entry the observation would read, then classifies it
   task automatic queue_classify(input int hr, input int wd, input int ds);
      scorer_req_type it;
      int          k;
      if (hr < NUM_HOURS_DEF && wd < NUM_DAYS_DEF && ds < NUM_DISTRICTS_DEF) begin
         for (k = 0; k < gen_classes; k++) begin
            if (!prior_seen[k])
               queue_write(TBL_PRIOR, $urandom_range(0, 31), k, draw_prob());
            if (!hour_seen[hr][k])
               queue_write(TBL_HOUR, hr, k, draw_prob());
            if (!day_seen[wd][k])
               queue_write(TBL_DAY, wd, k, draw_prob());
            if (!dist_seen[ds][k])
               queue_write(TBL_DIST, ds, k, draw_prob());
         end
      end
      it = random_item();
      it.func = FUNC_CLASSIFY;
      it.hr = 5'(hr);
      it.wd = 3'(wd);
      it.ds = 4'(ds);
      item_backlog.push_back(it);
      items_queued++;
      stim_count++;
   endtask

   task automatic settle();
      while (items_accepted != items_queued || posterior_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic readback_classes(input logic [5:0] want);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      csr_paddr <= REG_CLASSES;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[5:0] != want)
         flag_mismatch($sformatf("classes_in_use reads %0d, want %0d", csr_prdata[5:0], want));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_classes(input logic [5:0] value);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom;
      word[5:0] = value;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= REG_CLASSES;
      csr_pwdata <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      model_classes = value;
      gen_classes = effective_classes(value);
      csr_writes++;
      readback_classes(value);
   endtask

   task automatic random_phase(input int budget);
      int         stop_at;
      int         r;
      logic [1:0] sel;
      stop_at = stim_count + budget;
      while (stim_count < stop_at) begin
         r = $urandom_range(0, 19);
         sel = 2'($urandom);
         if (r <= 10) begin
            if ($urandom_range(0, 2) == 0)
               queue_write(sel, $urandom_range(0, row_limit(sel) - 1),
                           $urandom_range(0, gen_classes - 1), draw_prob());
            queue_classify($urandom_range(0, NUM_HOURS_DEF - 1), $urandom_range(0, NUM_DAYS_DEF - 1),
                           $urandom_range(0, NUM_DISTRICTS_DEF - 1));
         end else if (r <= 13) begin
            queue_write(sel, $urandom_range(0, row_limit(sel) - 1),
                        $urandom_range(0, NUM_CLASSES_DEF - 1), draw_prob());
         end else if (r <= 15) begin
            if (sel == TBL_PRIOR || $urandom_range(0, 1) == 0)
               queue_write(sel, $urandom_range(0, 31), $urandom_range(NUM_CLASSES_DEF, 63),
                           16'($urandom));
            else
               queue_write(sel, $urandom_range(row_limit(sel), 31),
                           $urandom_range(0, NUM_CLASSES_DEF - 1), 16'($urandom));
         end else if (r <= 17) begin
            case ($urandom_range(0, 2))
               0: queue_classify($urandom_range(NUM_HOURS_DEF, 31), $urandom_range(0, 7),
                                 $urandom_range(0, 15));
               1: queue_classify($urandom_range(0, 31), 7, $urandom_range(0, 15));
               default: queue_classify($urandom_range(0, 31), $urandom_range(0, 7),
                                       $urandom_range(NUM_DISTRICTS_DEF, 15));
            endcase
         end else begin
            queue_classify($urandom_range(0, 31), $urandom_range(0, 7), $urandom_range(0, 15));
         end
      end
   endtask

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      readback_classes(CLASSES_RESET);

      // single class: saturation, zero evidence, bad observations, dropped writes
      write_classes(6'd1);
      queue_write(TBL_PRIOR, 31, 0, 16'hFFFF);
      queue_write(TBL_HOUR, 0, 0, 16'hFFFF);
      queue_write(TBL_DAY, 0, 0, 16'hFFFF);
      queue_write(TBL_DIST, 0, 0, 16'hFFFF);
      queue_classify(0, 0, 0);
      queue_write(TBL_HOUR, 23, 0, 16'h0000);
      queue_write(TBL_DAY, 6, 0, 16'h0001);
      queue_write(TBL_DIST, 9, 0, 16'h0001);
      queue_classify(23, 6, 9);
      queue_classify(31, 7, 15);
      queue_classify(24, 0, 0);
      queue_classify(0, 7, 0);
      queue_classify(0, 0, 10);
      queue_write(TBL_PRIOR, 0, 63, 16'h1234);
      queue_write(TBL_HOUR, 31, 0, 16'h5555);
      queue_write(TBL_HOUR, 24, 0, 16'h5555);
      queue_write(TBL_DAY, 7, 0, 16'hAAAA);
      queue_write(TBL_DIST, 15, 0, 16'hAAAA);
      settle();

      // full class count at the corner observations
      write_classes(6'd39);
      queue_classify(23, 6, 9);
      queue_classify(0, 0, 0);
      settle();

      write_classes(6'd63);
      random_phase(20);
      settle();
      write_classes(6'd0);
      hold_request = 1;
      random_phase(40);
      settle();
      no_idle <= 1'b1;
      write_classes(6'($urandom_range(2, 8)));
      random_phase(50);
      settle();
      no_idle <= 1'b0;
      write_classes(6'd39);
      random_phase(20);
      settle();
      write_classes(6'($urandom_range(1, 39)));
      random_phase(30);
      settle();
      write_classes(6'($urandom_range(9, 20)));
      random_phase(40);
      settle();
      repeat (20) @(posedge clock);

      $display("run covered %0d items: %0d table writes kept, %0d dropped, %0d register writes",
               items_accepted, writes_kept, writes_dropped, csr_writes);
      $display("classified %0d ok, %0d zero-evidence, %0d out-of-range; %0d posteriors checked",
               scored_ok, scored_zero, scored_range, posteriors_seen);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
